[rtl/nnis_pkg.sv]
package nnis_pkg;

    // Field and register widths fixed by the interface.
    localparam int W_DIM      = 9;
    localparam int W_SCALE    = 16;
    localparam int W_COORD    = 12;
    localparam int W_OUT_DIM  = 13;
    localparam int W_CFG_IDX  = 2;
    localparam int W_CFG_DATA = 16;

    // Q4.12 scale: 12 fraction bits, so one output step is 4096 in source units.
    localparam int FRAC_BITS  = 12;
    localparam int DIV_STEPS  = FRAC_BITS + 1;
    localparam int W_DIV_CNT  = 4;
    localparam int W_QUOT     = FRAC_BITS + 1;

    localparam logic [W_OUT_DIM-1:0] OUT_LIMIT = 13'd4096;

    typedef logic [W_CFG_IDX-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SRC_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_SRC_HEIGHT = 2'd1;
    localparam t_cfg_idx CFG_SCALE      = 2'd2;

endpackage

[rtl/nearest_neighbor_image_scaler.sv]
// Channel  Direction  Handshake            Payload
// command  in         start & !busy        i_cmd, i_pixel_in
// config   in         i_cfg_we             i_cfg_idx, i_cfg_data
// result   out        o_strobe (1 cycle)   o_pixel_out, o_out_col, o_out_row,
//                                          o_last_pixel, o_done_res
//
// One word is taken per cycle while busy is low; a read word gives its result
// in the next cycle, after the frame store's registered read port.
// busy is high after reset and after every register write, while
// a shift-subtract divider forms 4096 / scale_q12 one quotient bit per cycle.
// Reset is synchronous and active low; the frame store is not cleared.
// The receiver cannot stall, so results are never held back.
module nearest_neighbor_image_scaler #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int PIXEL_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_cmd,
    input  logic [PIXEL_BITS-1:0]              i_pixel_in,
    input  logic                               i_cfg_we,
    input  nnis_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [nnis_pkg::W_CFG_DATA-1:0]    i_cfg_data,
    output logic                               o_strobe,
    output logic [PIXEL_BITS-1:0]              o_pixel_out,
    output logic [nnis_pkg::W_COORD-1:0]       o_out_col,
    output logic [nnis_pkg::W_COORD-1:0]       o_out_row,
    output logic                               o_last_pixel,
    output logic                               o_done_res
);
    import nnis_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW     = $clog2(DEPTH + 1);
    localparam int W_NPIX = 2 * W_DIM;
    localparam int W_ADDR = 2 * W_DIM + 1;
    localparam int W_PROD = W_DIM + W_SCALE;

    // Frame store.
    logic [PIXEL_BITS-1:0] mem [DEPTH];
    logic [PIXEL_BITS-1:0] r_rd_data;

    // Configuration and derived sizes.
    logic [W_DIM-1:0]     r_sw, r_sh;
    logic [W_SCALE-1:0]   r_scale;
    logic [W_OUT_DIM-1:0] r_ow, r_oh;
    logic [W_NPIX-1:0]    r_npix;

    // Divider: forms the per-step quotient and remainder in place.
    logic [W_DIV_CNT-1:0] r_div_cnt;
    logic [W_QUOT-1:0]    r_step_q;
    logic [W_SCALE-1:0]   r_step_r;

    // Scan counters.
    logic [LW-1:0]        r_load_cnt;
    logic [W_COORD-1:0]   r_col, r_row;
    logic [W_QUOT-1:0]    r_qx, r_qy;
    logic [W_SCALE-1:0]   r_rx, r_ry;
    logic                 r_finished;

    // Result register.
    logic                 r_strobe, r_done, r_last;
    logic [W_COORD-1:0]   r_out_col, r_out_row;

    logic                 cfg_hit, accept, do_load, do_read, empty, load_ok;
    logic [W_DIM-1:0]     sw_eff, sh_eff, sx, sy;
    logic [W_PROD-1:0]    ow_prod, oh_prod;
    logic [W_OUT_DIM-1:0] ow_full, oh_full;
    logic [W_ADDR-1:0]    rd_addr_full;
    logic [AW-1:0]        rd_addr, wr_addr;
    logic [W_SCALE:0]     div_t, rx_sum, ry_sum;
    logic                 div_bit, cx, cy, col_wrap, row_wrap;
    logic [W_SCALE-1:0]   n_rx, n_ry;
    logic [W_QUOT-1:0]    n_qx, n_qy;

    assign cfg_hit = i_cfg_we && (i_cfg_idx == CFG_SRC_WIDTH || i_cfg_idx == CFG_SRC_HEIGHT
                                  || i_cfg_idx == CFG_SCALE);
    assign busy    = (r_div_cnt != '0);
    assign accept  = start && !busy;
    assign do_load = accept && !i_cmd;
    assign do_read = accept && i_cmd;

    assign sw_eff = (r_sw > MAX_WIDTH)  ? W_DIM'(MAX_WIDTH)  : r_sw;
    assign sh_eff = (r_sh > MAX_HEIGHT) ? W_DIM'(MAX_HEIGHT) : r_sh;

    assign ow_prod = W_PROD'(sw_eff) * W_PROD'(r_scale);
    assign oh_prod = W_PROD'(sh_eff) * W_PROD'(r_scale);
    assign ow_full = (ow_prod[W_PROD-1:FRAC_BITS] > W_PROD'(OUT_LIMIT))
                     ? OUT_LIMIT : W_OUT_DIM'(ow_prod[W_PROD-1:FRAC_BITS]);
    assign oh_full = (oh_prod[W_PROD-1:FRAC_BITS] > W_PROD'(OUT_LIMIT))
                     ? OUT_LIMIT : W_OUT_DIM'(oh_prod[W_PROD-1:FRAC_BITS]);

    // Restoring division of 4096 by the scale: the dividend's only set bit
    // enters on the first iteration.
    assign div_bit = (r_div_cnt == W_DIV_CNT'(DIV_STEPS));
    assign div_t   = {r_step_r, div_bit};

    assign load_ok = (W_NPIX'(r_load_cnt) < r_npix) && (r_load_cnt < LW'(DEPTH));
    assign wr_addr = AW'(r_load_cnt);

    assign empty = r_finished || (r_ow == '0) || (r_oh == '0)
                   || ({1'b0, r_col} >= r_ow) || ({1'b0, r_row} >= r_oh);

    // The quotient never passes the source size while the output position is
    // in range, but the clamp keeps the address inside the image regardless.
    assign sx = (r_qx >= W_QUOT'(sw_eff)) ? sw_eff - 1'b1 : W_DIM'(r_qx);
    assign sy = (r_qy >= W_QUOT'(sh_eff)) ? sh_eff - 1'b1 : W_DIM'(r_qy);
    assign rd_addr_full = W_ADDR'(W_NPIX'(sy) * W_NPIX'(sw_eff)) + W_ADDR'(sx);
    assign rd_addr      = AW'(rd_addr_full);

    // Each output step adds 4096 to the scaled coordinate: quotient by the
    // precomputed step, plus one when the remainder overflows the scale.
    assign rx_sum = {1'b0, r_rx} + {1'b0, r_step_r};
    assign cx     = (rx_sum >= {1'b0, r_scale});
    assign n_rx   = cx ? W_SCALE'(rx_sum - {1'b0, r_scale}) : W_SCALE'(rx_sum);
    assign n_qx   = r_qx + r_step_q + W_QUOT'(cx);
    assign ry_sum = {1'b0, r_ry} + {1'b0, r_step_r};
    assign cy     = (ry_sum >= {1'b0, r_scale});
    assign n_ry   = cy ? W_SCALE'(ry_sum - {1'b0, r_scale}) : W_SCALE'(ry_sum);
    assign n_qy   = r_qy + r_step_q + W_QUOT'(cy);

    assign col_wrap = ({1'b0, r_col} + 1'b1) >= r_ow;
    assign row_wrap = ({1'b0, r_row} + 1'b1) >= r_oh;

    always_ff @(posedge i_clk) begin
        if (do_load && load_ok) begin
            mem[wr_addr] <= i_pixel_in;
        end
        if (do_read && !empty) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ow   <= ow_full;
        r_oh   <= oh_full;
        r_npix <= W_NPIX'(sw_eff) * W_NPIX'(sh_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw       <= W_DIM'(1);
            r_sh       <= W_DIM'(1);
            r_scale    <= W_SCALE'(4096);
            r_div_cnt  <= W_DIV_CNT'(DIV_STEPS);
            r_step_q   <= '0;
            r_step_r   <= '0;
            r_load_cnt <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_qx       <= '0;
            r_qy       <= '0;
            r_rx       <= '0;
            r_ry       <= '0;
            r_finished <= 1'b0;
            r_strobe   <= 1'b0;
        end else if (cfg_hit) begin
            unique case (i_cfg_idx)
                CFG_SRC_WIDTH:  r_sw    <= W_DIM'(i_cfg_data);
                CFG_SRC_HEIGHT: r_sh    <= W_DIM'(i_cfg_data);
                default:        r_scale <= i_cfg_data;
            endcase
            r_div_cnt  <= W_DIV_CNT'(DIV_STEPS);
            r_step_q   <= '0;
            r_step_r   <= '0;
            r_load_cnt <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_qx       <= '0;
            r_qy       <= '0;
            r_rx       <= '0;
            r_ry       <= '0;
            r_finished <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            if (busy) begin
                r_div_cnt <= r_div_cnt - 1'b1;
                if (div_t >= {1'b0, r_scale}) begin
                    r_step_r <= W_SCALE'(div_t - {1'b0, r_scale});
                    r_step_q <= {r_step_q[W_QUOT-2:0], 1'b1};
                end else begin
                    r_step_r <= W_SCALE'(div_t);
                    r_step_q <= {r_step_q[W_QUOT-2:0], 1'b0};
                end
            end
            if (do_load && load_ok) begin
                r_load_cnt <= r_load_cnt + 1'b1;
            end
            r_strobe <= do_read;
            if (do_read) begin
                if (empty) begin
                    r_finished <= 1'b1;
                end else if (!col_wrap) begin
                    r_col <= r_col + 1'b1;
                    r_qx  <= n_qx;
                    r_rx  <= n_rx;
                end else begin
                    r_col <= '0;
                    r_qx  <= '0;
                    r_rx  <= '0;
                    if (!row_wrap) begin
                        r_row <= r_row + 1'b1;
                        r_qy  <= n_qy;
                        r_ry  <= n_ry;
                    end else begin
                        r_row      <= '0;
                        r_qy       <= '0;
                        r_ry       <= '0;
                        r_finished <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_read) begin
            r_done    <= empty;
            r_last    <= !empty && col_wrap && row_wrap;
            r_out_col <= empty ? '0 : r_col;
            r_out_row <= empty ? '0 : r_row;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_pixel_out  = r_done ? '0 : r_rd_data;
    assign o_out_col    = r_out_col;
    assign o_out_row    = r_out_row;
    assign o_last_pixel = r_last;
    assign o_done_res   = r_done;

endmodule
